// ----- sv/cfla_pkg.sv -----
// Shared types and constants of the chunked free-list allocator.
`default_nettype none

package cfla_pkg;

    localparam int CHUNKS_DEF      = 4;
    localparam int MAX_BLOCKS_DEF  = 255;
    localparam int SLOT_W          = 8;
    localparam int SLOTS_PER_CHUNK = 256;
    localparam int BLOCK_SIZE_W    = 9;
    localparam int BPC_W           = 8;
    localparam int CHUNK_FIELD_W   = 2;
    localparam int OFFSET_W        = 16;
    localparam int STATUS_W        = 2;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 9;

    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = 9'd8;
    localparam logic [BPC_W-1:0]        BPC_RST        = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_PER_CHUNK = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OOM      = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_READ = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic                     op;
        logic [CHUNK_FIELD_W-1:0] chunk;
        logic [SLOT_W-1:0]        block;
    } request_t;

    typedef struct packed {
        status_t                  status;
        logic [CHUNK_FIELD_W-1:0] chunk;
        logic [SLOT_W-1:0]        block;
        logic [OFFSET_W-1:0]      byte_offset;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/cfla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/cfla_ctrl.sv -----
// Allocation sequencer: chunk table, link memory access and chunk activation sweep.
`default_nettype none

module cfla_ctrl #(
    parameter int CHUNKS = cfla_pkg::CHUNKS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire cfla_pkg::request_t                req,
    input  wire logic [cfla_pkg::BLOCK_SIZE_W-1:0] block_size,
    input  wire logic [cfla_pkg::BPC_W-1:0]        eff_blocks,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output cfla_pkg::result_t                      res
);

    localparam int CIW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int ACW = $clog2(CHUNKS + 1);
    localparam int AW  = CIW + cfla_pkg::SLOT_W;
    localparam int PW  = cfla_pkg::SLOT_W + cfla_pkg::BLOCK_SIZE_W;

    cfla_pkg::state_t            st_reg;
    logic [cfla_pkg::SLOT_W-1:0] head_reg [CHUNKS];
    logic [cfla_pkg::SLOT_W-1:0] cnt_reg  [CHUNKS];
    logic [ACW-1:0]              active_reg;
    logic [CIW-1:0]              cursor_reg;
    logic                        cursor_vld_reg;
    logic [CIW-1:0]              cur_reg;
    logic [cfla_pkg::SLOT_W-1:0] sweep_reg;
    cfla_pkg::result_t           res_reg;

    logic                        accept;
    logic                        found;
    logic [CIW-1:0]              fidx;
    logic                        cursor_hit;
    logic                        can_activate;
    logic [CIW-1:0]              sel_c;
    logic [CIW+1:0]              fc_wide;
    logic [CIW-1:0]              fc;
    logic                        free_ok;
    logic [cfla_pkg::SLOT_W-1:0] mul_a;
    logic [PW-1:0]               prod;
    logic [cfla_pkg::OFFSET_W-1:0] offset;
    logic [CIW+1:0]              cur_wide;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [cfla_pkg::SLOT_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [cfla_pkg::SLOT_W-1:0] ram_rdata;

    assign accept    = req_valid && req_ready;
    assign req_ready = (st_reg == cfla_pkg::S_IDLE);
    assign res_valid = (st_reg == cfla_pkg::S_DONE);
    assign res       = res_reg;

    always_comb begin
        found = 1'b0;
        fidx  = '0;
        for (int i = CHUNKS - 1; i >= 0; i--) begin
            if ((ACW'(i) < active_reg) && (cnt_reg[i] != '0)) begin
                found = 1'b1;
                fidx  = CIW'(i);
            end
        end
    end

    assign cursor_hit   = cursor_vld_reg && (cnt_reg[cursor_reg] != '0);
    assign can_activate = (active_reg < ACW'(CHUNKS)) && (eff_blocks != '0);
    assign sel_c        = cursor_hit ? cursor_reg : fidx;

    assign fc_wide = {{CIW{1'b0}}, req.chunk};
    assign fc      = fc_wide[CIW-1:0];
    assign free_ok = ({{ACW{1'b0}}, req.chunk} < {2'b00, active_reg})
                     && (req.block < eff_blocks);

    assign cur_wide = {2'b00, cur_reg};

    assign mul_a  = (st_reg == cfla_pkg::S_WAIT) ? head_reg[cur_reg] : req.block;
    assign prod   = PW'(mul_a) * PW'(block_size);
    assign offset = (prod > PW'({cfla_pkg::OFFSET_W{1'b1}})) ?
                    {cfla_pkg::OFFSET_W{1'b1}} : prod[cfla_pkg::OFFSET_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {cur_reg, sweep_reg};
        ram_wdata = sweep_reg + cfla_pkg::SLOT_W'(1);
        if (st_reg == cfla_pkg::S_READ) begin
            ram_raddr = {cur_reg, head_reg[cur_reg]};
        end else begin
            ram_raddr = {sel_c, head_reg[sel_c]};
        end
        if (st_reg == cfla_pkg::S_INIT) begin
            ram_we = 1'b1;
        end else if (accept && (req.op == cfla_pkg::OP_FREE) && free_ok) begin
            ram_we    = 1'b1;
            ram_waddr = {fc, req.block};
            ram_wdata = head_reg[fc];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= cfla_pkg::S_IDLE;
            active_reg     <= '0;
            cursor_reg     <= '0;
            cursor_vld_reg <= 1'b0;
            for (int i = 0; i < CHUNKS; i++) begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            case (st_reg)
                cfla_pkg::S_IDLE: begin
                    if (accept) begin
                        if (req.op == cfla_pkg::OP_FREE) begin
                            if (free_ok) begin
                                head_reg[fc] <= req.block;
                                cnt_reg[fc]  <= cnt_reg[fc] + cfla_pkg::SLOT_W'(1);
                                res_reg      <= '{cfla_pkg::STATUS_OK, req.chunk,
                                                  req.block, offset};
                            end else begin
                                res_reg <= '{cfla_pkg::STATUS_BAD_FREE, '0, '0, '0};
                            end
                            st_reg <= cfla_pkg::S_DONE;
                        end else if (cursor_hit || found) begin
                            cur_reg        <= sel_c;
                            cursor_reg     <= sel_c;
                            cursor_vld_reg <= 1'b1;
                            st_reg         <= cfla_pkg::S_WAIT;
                        end else if (can_activate) begin
                            cur_reg   <= active_reg[CIW-1:0];
                            sweep_reg <= '0;
                            st_reg    <= cfla_pkg::S_INIT;
                        end else begin
                            res_reg <= '{cfla_pkg::STATUS_OOM, '0, '0, '0};
                            st_reg  <= cfla_pkg::S_DONE;
                        end
                    end
                end
                cfla_pkg::S_INIT: begin
                    sweep_reg <= sweep_reg + cfla_pkg::SLOT_W'(1);
                    if (sweep_reg == eff_blocks - cfla_pkg::SLOT_W'(1)) begin
                        head_reg[cur_reg] <= '0;
                        cnt_reg[cur_reg]  <= eff_blocks;
                        active_reg        <= active_reg + ACW'(1);
                        cursor_reg        <= cur_reg;
                        cursor_vld_reg    <= 1'b1;
                        st_reg            <= cfla_pkg::S_READ;
                    end
                end
                cfla_pkg::S_READ: begin
                    st_reg <= cfla_pkg::S_WAIT;
                end
                cfla_pkg::S_WAIT: begin
                    head_reg[cur_reg] <= ram_rdata;
                    cnt_reg[cur_reg]  <= cnt_reg[cur_reg] - cfla_pkg::SLOT_W'(1);
                    res_reg           <= '{cfla_pkg::STATUS_OK, cur_wide[1:0],
                                           head_reg[cur_reg], offset};
                    st_reg            <= cfla_pkg::S_DONE;
                end
                cfla_pkg::S_DONE: begin
                    if (res_ready) begin
                        st_reg <= cfla_pkg::S_IDLE;
                    end
                end
                default: begin
                    st_reg <= cfla_pkg::S_IDLE;
                end
            endcase
        end
    end

    cfla_ram #(
        .WIDTH(cfla_pkg::SLOT_W),
        .DEPTH(CHUNKS * cfla_pkg::SLOTS_PER_CHUNK)
    ) u_link_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == cfla_pkg::S_WAIT) |-> (cnt_reg[cur_reg] != '0))
        else $error("pop from a chunk with no free blocks");

    a_no_write_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == cfla_pkg::S_WAIT || st_reg == cfla_pkg::S_READ) |-> !ram_we)
        else $error("link write during a pop");

    a_active_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg <= ACW'(CHUNKS))
        else $error("active chunk count beyond chunk capacity");

    a_activation_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == cfla_pkg::S_INIT && $past(st_reg) == cfla_pkg::S_IDLE)
        |-> (cur_reg == active_reg[CIW-1:0] && sweep_reg == '0))
        else $error("activation sweep started at the wrong chunk");
`endif

endmodule

`default_nettype wire

// ----- sv/chunked_free_list_allocator.sv -----
// Top level of the chunked free-list allocator: registers, output stage and sequencer.
//
// Channel  Direction  Handshake          Word
// cfg      in         cfg_we             cfg_index, cfg_wdata
// s_       in         s_valid/s_ready    s_op, s_free_chunk, s_free_block
// m_       out        m_valid/m_ready    m_status, m_chunk, m_block, m_byte_offset
//
// Free and failed allocate: accept goes straight to S_DONE, then the output register.
// Allocate from a chunk with free blocks: S_WAIT takes the registered link memory read.
// Allocate that activates a chunk: S_INIT writes one link a cycle, then S_READ, S_WAIT.
// Reset empties chunk table, presets cfg registers; link memory needs no clearing.
// One word is in flight; s_ready returns while a result waits in the output register.
`default_nettype none

module chunked_free_list_allocator #(
    parameter int CHUNKS     = cfla_pkg::CHUNKS_DEF,
    parameter int MAX_BLOCKS = cfla_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [cfla_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [cfla_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic [cfla_pkg::CHUNK_FIELD_W-1:0]  s_free_chunk,
    input  wire logic [cfla_pkg::SLOT_W-1:0]         s_free_block,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [cfla_pkg::STATUS_W-1:0]            m_status,
    output logic [cfla_pkg::CHUNK_FIELD_W-1:0]       m_chunk,
    output logic [cfla_pkg::SLOT_W-1:0]              m_block,
    output logic [cfla_pkg::OFFSET_W-1:0]            m_byte_offset
);

    localparam logic [cfla_pkg::BPC_W-1:0] MAXB = cfla_pkg::BPC_W'(MAX_BLOCKS);

    logic [cfla_pkg::BLOCK_SIZE_W-1:0] block_size_reg;
    logic [cfla_pkg::BPC_W-1:0]        bpc_reg;
    logic [cfla_pkg::BPC_W-1:0]        eff_blocks;
    logic                              m_valid_reg;
    cfla_pkg::result_t                 out_reg;
    cfla_pkg::request_t                req;
    cfla_pkg::result_t                 res;
    logic                              res_valid;
    logic                              res_ready;

    assign eff_blocks = (bpc_reg > MAXB) ? MAXB : bpc_reg;
    assign req        = '{s_op, s_free_chunk, s_free_block};
    assign res_ready  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= cfla_pkg::BLOCK_SIZE_RST;
            bpc_reg        <= cfla_pkg::BPC_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                cfla_pkg::REG_BLOCK_SIZE:       block_size_reg <= cfg_wdata;
                cfla_pkg::REG_BLOCKS_PER_CHUNK: bpc_reg <= cfg_wdata[cfla_pkg::BPC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_chunk       = out_reg.chunk;
    assign m_block       = out_reg.block;
    assign m_byte_offset = out_reg.byte_offset;

    cfla_ctrl #(
        .CHUNKS(CHUNKS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .block_size(block_size_reg),
        .eff_blocks(eff_blocks),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

// ----- sim/tb_chunked_free_list_allocator.sv -----
// Self-checking bench for the chunked free-list allocator under random allocate/free traffic.
module tb_chunked_free_list_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCHUNK        = cfla_pkg::CHUNKS_DEF;
    localparam int SETTLE_CYCLES = 300;
    localparam int TAG_W         = cfla_pkg::CHUNK_FIELD_W + cfla_pkg::SLOT_W;

    typedef enum logic [1:0] {RX_STREAM, RX_CHOPPY, RX_BLOCKY} rx_mode_t;

    logic                                   aclk;
    logic                                   aresetn      = 1'b0;
    logic                                   cfg_we       = 1'b0;
    logic [cfla_pkg::CFG_INDEX_W-1:0]       cfg_index    = '0;
    logic [cfla_pkg::CFG_DATA_W-1:0]        cfg_wdata    = '0;
    logic                                   s_valid      = 1'b0;
    logic                                   s_ready;
    logic                                   s_op         = 1'b0;
    logic [cfla_pkg::CHUNK_FIELD_W-1:0]     s_free_chunk = '0;
    logic [cfla_pkg::SLOT_W-1:0]            s_free_block = '0;
    logic                                   m_valid;
    logic                                   m_ready      = 1'b0;
    logic [cfla_pkg::STATUS_W-1:0]          m_status;
    logic [cfla_pkg::CHUNK_FIELD_W-1:0]     m_chunk;
    logic [cfla_pkg::SLOT_W-1:0]            m_block;
    logic [cfla_pkg::OFFSET_W-1:0]          m_byte_offset;

    chunked_free_list_allocator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_free_chunk  (s_free_chunk),
        .s_free_block  (s_free_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_chunk       (m_chunk),
        .m_block       (m_block),
        .m_byte_offset (m_byte_offset)
    );

    // allocator shadow
    logic [cfla_pkg::SLOT_W-1:0]       next_link [NCHUNK*cfla_pkg::SLOTS_PER_CHUNK];
    logic [cfla_pkg::SLOT_W-1:0]       list_head [NCHUNK] = '{default: '0};
    logic [cfla_pkg::SLOT_W-1:0]       free_count [NCHUNK] = '{default: '0};
    int unsigned                       live_chunks  = 0;
    int unsigned                       cached_chunk = 0;
    bit                                cache_ok     = 1'b0;
    logic [cfla_pkg::BLOCK_SIZE_W-1:0] block_bytes  = cfla_pkg::BLOCK_SIZE_RST;
    logic [cfla_pkg::BPC_W-1:0]        chunk_blocks = cfla_pkg::BPC_RST;

    cfla_pkg::request_t      pending_requests [$];
    cfla_pkg::result_t       responses_owed [$];
    logic [TAG_W-1:0]        held_blocks [$];

    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left  = 0;
    int unsigned mode_left  = 0;
    rx_mode_t    rx_mode    = RX_STREAM;

    int unsigned n_words    = 0;
    int unsigned n_grants   = 0;
    int unsigned n_oom      = 0;
    int unsigned n_frees    = 0;
    int unsigned n_rejects  = 0;
    int unsigned n_results  = 0;
    int unsigned n_mismatch = 0;
    int unsigned peak_held  = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [cfla_pkg::OFFSET_W-1:0] offset_of_block(
        logic [cfla_pkg::SLOT_W-1:0] blk);
        logic [cfla_pkg::OFFSET_W:0] prod;
        prod = (cfla_pkg::OFFSET_W+1)'(blk) * (cfla_pkg::OFFSET_W+1)'(block_bytes);
        return (prod > (cfla_pkg::OFFSET_W+1)'(17'hFFFF)) ? 16'hFFFF
                                                          : prod[cfla_pkg::OFFSET_W-1:0];
    endfunction

    function automatic cfla_pkg::result_t serve_request(cfla_pkg::request_t req);
        cfla_pkg::result_t r;
        int unsigned       c;
        int unsigned       i;
        bit                found;
        r = '0;
        if (req.op == cfla_pkg::OP_ALLOC) begin
            found = cache_ok && free_count[cached_chunk] != '0;
            for (i = 0; i < live_chunks; i++) begin
                if (!found && free_count[i] != '0) begin
                    cached_chunk = i;
                    cache_ok     = 1'b1;
                    found        = 1'b1;
                end
            end
            if (!found && live_chunks < NCHUNK && chunk_blocks != '0) begin
                for (i = 0; i < int'(chunk_blocks); i++) begin
                    next_link[live_chunks*cfla_pkg::SLOTS_PER_CHUNK + i] =
                        cfla_pkg::SLOT_W'(i + 1);
                end
                list_head[live_chunks]  = '0;
                free_count[live_chunks] = chunk_blocks;
                cached_chunk = live_chunks;
                cache_ok     = 1'b1;
                live_chunks  = live_chunks + 1;
                found        = 1'b1;
            end
            if (found) begin
                c             = cached_chunk;
                r.status      = cfla_pkg::STATUS_OK;
                r.chunk       = cfla_pkg::CHUNK_FIELD_W'(c);
                r.block       = list_head[c];
                r.byte_offset = offset_of_block(list_head[c]);
                list_head[c]  = next_link[c*cfla_pkg::SLOTS_PER_CHUNK + int'(list_head[c])];
                free_count[c] = free_count[c] - cfla_pkg::SLOT_W'(1);
            end else begin
                r.status = cfla_pkg::STATUS_OOM;
            end
        end else if (int'(req.chunk) >= live_chunks || req.block >= chunk_blocks) begin
            r.status = cfla_pkg::STATUS_BAD_FREE;
        end else begin
            c = int'(req.chunk);
            next_link[c*cfla_pkg::SLOTS_PER_CHUNK + int'(req.block)] = list_head[c];
            list_head[c]  = req.block;
            free_count[c] = free_count[c] + cfla_pkg::SLOT_W'(1);
            r.status      = cfla_pkg::STATUS_OK;
            r.chunk       = req.chunk;
            r.block       = req.block;
            r.byte_offset = offset_of_block(req.block);
        end
        return r;
    endfunction

    always @(posedge aclk) begin : drive_requests
        cfla_pkg::request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0 || pending_requests.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end
            end else begin
                nxt = pending_requests.pop_front();
                s_valid      <= 1'b1;
                s_op         <= nxt.op;
                s_free_chunk <= nxt.chunk;
                s_free_block <= nxt.block;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= $urandom_range(0, 8);
                end
            end
        end
    end

    always @(posedge aclk) begin : pace_results
        if (mode_left == 0) begin
            mode_left <= $urandom_range(50, 300);
            rx_mode   <= rx_mode_t'($urandom_range(0, 2));
        end else begin
            mode_left <= mode_left - 1;
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (rx_mode)
                RX_CHOPPY: begin
                    if ($urandom_range(1) == 0) begin
                        m_ready   <= 1'b0;
                        hold_left <= $urandom_range(0, 2);
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
                RX_BLOCKY: begin
                    if ($urandom_range(15) == 0) begin
                        m_ready   <= 1'b0;
                        hold_left <= $urandom_range(4, 39);
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
                default: begin
                    m_ready <= 1'b1;
                end
            endcase
        end
    end

    always @(posedge aclk) begin : watch_ports
        cfla_pkg::request_t seen;
        cfla_pkg::result_t  want;
        cfla_pkg::result_t  made;
        logic [TAG_W-1:0]   tag;
        int                 k;
        if (aresetn && m_valid && m_ready) begin
            if (responses_owed.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("result %0d unexpected: st=%0d chunk=%0d blk=%0d off=%0d",
                             n_results, m_status, m_chunk, m_block, m_byte_offset);
                end
            end else begin
                want = responses_owed.pop_front();
                if (m_status !== want.status || m_chunk !== want.chunk ||
                    m_block !== want.block || m_byte_offset !== want.byte_offset) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("result %0d: expected st=%0d chunk=%0d blk=%0d off=%0d",
                                 n_results, want.status, want.chunk, want.block,
                                 want.byte_offset);
                        $display("    got st=%0d chunk=%0d blk=%0d off=%0d",
                                 m_status, m_chunk, m_block, m_byte_offset);
                    end
                end
            end
            n_results++;
        end
        if (aresetn && s_valid && s_ready) begin
            seen = {s_op, s_free_chunk, s_free_block};
            made = serve_request(seen);
            responses_owed.insert(responses_owed.size(), made);
            n_words++;
            tag = {made.chunk, made.block};
            if (made.status == cfla_pkg::STATUS_OOM) begin
                n_oom++;
            end else if (made.status == cfla_pkg::STATUS_BAD_FREE) begin
                n_rejects++;
            end else if (seen.op == cfla_pkg::OP_ALLOC) begin
                n_grants++;
                held_blocks.insert(held_blocks.size(), tag);
                if (held_blocks.size() > peak_held) begin
                    peak_held = held_blocks.size();
                end
            end else begin
                n_frees++;
                for (k = 0; k < held_blocks.size(); k++) begin
                    if (held_blocks[k] == tag) begin
                        held_blocks.delete(k);
                        break;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [cfla_pkg::CFG_INDEX_W-1:0] idx,
                             logic [cfla_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == cfla_pkg::REG_BLOCK_SIZE) begin
            block_bytes = val;
        end else begin
            chunk_blocks = val[cfla_pkg::BPC_W-1:0];
        end
        @(negedge aclk);
    endtask

    task automatic offer(logic op, int unsigned chunk, int unsigned blk);
        cfla_pkg::request_t req;
        req.op    = op;
        req.chunk = cfla_pkg::CHUNK_FIELD_W'(chunk);
        req.block = cfla_pkg::SLOT_W'(blk);
        pending_requests.insert(pending_requests.size(), req);
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || responses_owed.size() != 0);
    endtask

    task automatic churn(int unsigned bs, int unsigned bpc, int unsigned alloc_pct,
                         int unsigned words);
        int unsigned        roll;
        int unsigned        pick;
        cfla_pkg::request_t req;
        write_reg(cfla_pkg::REG_BLOCK_SIZE, cfla_pkg::CFG_DATA_W'(bs));
        write_reg(cfla_pkg::REG_BLOCKS_PER_CHUNK, cfla_pkg::CFG_DATA_W'(bpc));
        repeat (words) begin
            while (pending_requests.size() != 0 || s_valid) @(negedge aclk);
            roll      = $urandom_range(99);
            req.chunk = cfla_pkg::CHUNK_FIELD_W'($urandom);
            req.block = cfla_pkg::SLOT_W'($urandom);
            if (roll >= 96) begin
                req.op = cfla_pkg::OP_FREE;
            end else if (roll < alloc_pct || held_blocks.size() == 0) begin
                req.op = cfla_pkg::OP_ALLOC;
            end else begin
                pick = $urandom_range(held_blocks.size() - 1);
                req.op = cfla_pkg::OP_FREE;
                {req.chunk, req.block} = held_blocks[pick];
            end
            pending_requests.insert(pending_requests.size(), req);
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(cfla_pkg::REG_BLOCKS_PER_CHUNK, '0);
        write_reg(cfla_pkg::REG_BLOCK_SIZE, 9'd511);
        offer(cfla_pkg::OP_ALLOC, 0, 0);
        offer(cfla_pkg::OP_FREE, 0, 0);
        offer(cfla_pkg::OP_FREE, 3, 255);
        drain();

        write_reg(cfla_pkg::REG_BLOCKS_PER_CHUNK, 9'd1);
        write_reg(cfla_pkg::REG_BLOCK_SIZE, 9'd256);
        offer(cfla_pkg::OP_ALLOC, 3, 255);
        offer(cfla_pkg::OP_ALLOC, 0, 0);
        offer(cfla_pkg::OP_FREE, 0, 0);
        offer(cfla_pkg::OP_ALLOC, 0, 0);
        offer(cfla_pkg::OP_FREE, 1, 1);
        offer(cfla_pkg::OP_FREE, 1, 0);
        offer(cfla_pkg::OP_FREE, 1, 0);
        drain();

        write_reg(cfla_pkg::REG_BLOCKS_PER_CHUNK, 9'd255);
        write_reg(cfla_pkg::REG_BLOCK_SIZE, 9'd511);
        offer(cfla_pkg::OP_ALLOC, 0, 0);
        offer(cfla_pkg::OP_ALLOC, 0, 0);
        offer(cfla_pkg::OP_ALLOC, 0, 0);
        offer(cfla_pkg::OP_ALLOC, 0, 0);
        offer(cfla_pkg::OP_FREE, 2, 255);
        offer(cfla_pkg::OP_FREE, 2, 1);
        offer(cfla_pkg::OP_FREE, 3, 0);
        offer(cfla_pkg::OP_FREE, 1, 5);
        drain();

        churn(511, 7, 90, 400);
        churn(256, 128, 30, 330);
        churn(1, 255, 55, 330);
        churn($urandom_range(1, 256), $urandom_range(1, 255), 50, 330);
        churn($urandom_range(1, 256), $urandom_range(1, 255), 65, 330);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("%0d words: %0d grants, %0d out of memory, %0d frees, %0d bad frees",
                 n_words, n_grants, n_oom, n_frees, n_rejects);
        $display("%0d chunks brought up, %0d results checked, peak %0d blocks held",
                 live_chunks, n_results, peak_held);
        if (n_mismatch == 0 && responses_owed.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
